@@ rtl/awre_pkg.sv @@
package awre_pkg;

  localparam int DEF_WINDOW_SLOTS = 8;
  localparam int DEF_SERIAL_MAX   = 999;
  localparam int MAX_RESULTS      = 8;

  localparam int REQ_W    = 3;
  localparam int SERIAL_W = 10;
  localparam int KIND_W   = 3;
  localparam int SLOT_W   = 3;
  localparam int CFG_W    = 8;
  localparam int CIDX_W   = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_START    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_STOP     = 3'd1;
  localparam logic [REQ_W-1:0] REQ_FLOW_OFF = 3'd2;
  localparam logic [REQ_W-1:0] REQ_FLOW_ON  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SEND     = 3'd4;
  localparam logic [REQ_W-1:0] REQ_ACK      = 3'd5;
  localparam logic [REQ_W-1:0] REQ_TICK     = 3'd6;

  // event codes
  localparam logic [KIND_W-1:0] EV_TRANSMIT   = 3'd0;
  localparam logic [KIND_W-1:0] EV_RETRANSMIT = 3'd1;
  localparam logic [KIND_W-1:0] EV_DELIVERED  = 3'd2;
  localparam logic [KIND_W-1:0] EV_FAILED     = 3'd3;
  localparam logic [KIND_W-1:0] EV_REJECTED   = 3'd4;
  localparam logic [KIND_W-1:0] EV_READY      = 3'd5;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_WINDOW_LIMIT = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_MAX_TX       = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_ACK_TIMEOUT  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SERIAL_W-1:0] serial;
    logic                dup;
    logic [SLOT_W-1:0]   slot;
  } res_t;

  typedef struct packed {
    logic [SERIAL_W-1:0] serial;
    logic [3:0]          retries;
    logic [7:0]          countdown;
  } slot_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
    logic pop;
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
    logic has_results;
    logic pop_last;
  } sts_t;

endpackage

@@ rtl/awre_req_if.sv @@
interface awre_req_if;
  import awre_pkg::*;
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic                message_empty;
  logic [SERIAL_W-1:0] ack_serial;
  logic                ack_list_end;

  modport source (output valid, req_type, message_empty, ack_serial, ack_list_end,
                  input ready);
  modport sink (input valid, req_type, message_empty, ack_serial, ack_list_end,
                output ready);
endinterface

@@ rtl/awre_evt_if.sv @@
interface awre_evt_if;
  import awre_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   event_kind;
  logic [SERIAL_W-1:0] serial_number;
  logic                duplicate_mark;
  logic [SLOT_W-1:0]   slot_index;
  logic                ready_now;
  logic                last_result;

  modport source (output valid, event_kind, serial_number, duplicate_mark, slot_index,
                  ready_now, last_result, input ready);
  modport sink (input valid, event_kind, serial_number, duplicate_mark, slot_index,
                ready_now, last_result, output ready);
endinterface

@@ rtl/awre_ram.sv @@
module awre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/awre_ctrl.sv @@
module awre_ctrl import awre_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_FINISH = 4'b0100,
    S_EMIT   = 4'b1000
  } state_t;

  state_t state, state_next;

  // sequence one item: scan, finish, then hand out results
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = sts.need_scan ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_done) state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!sts.has_results) begin
          state_next = S_IDLE;
        end else begin
          out_valid = 1'b1;
          cmd.pop   = out_ready;
          if (out_ready && sts.pop_last) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

@@ rtl/awre_dp.sv @@
module awre_dp import awre_pkg::*; #(
  parameter int WINDOW_SLOTS = DEF_WINDOW_SLOTS,
  parameter int SERIAL_MAX   = DEF_SERIAL_MAX
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic [REQ_W-1:0]    req_type,
  input  logic                message_empty,
  input  logic [SERIAL_W-1:0] ack_serial,
  input  logic                ack_list_end,
  input  cmd_t                cmd,
  output sts_t                sts,
  output res_t                res,
  output logic                ready_now,
  output logic                last_result
);
  localparam int IW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int PW = $clog2(WINDOW_SLOTS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(WINDOW_SLOTS - 1);
  localparam logic [SERIAL_W-1:0] SMAX = SERIAL_W'(SERIAL_MAX);

  // configuration
  logic [3:0] window_limit, max_tx;
  logic [7:0] ack_timeout;

  // link state
  logic                    stopped, held;
  logic [SERIAL_W-1:0]     counter;
  logic [WINDOW_SLOTS-1:0] valid;
  logic [PW-1:0]           pend;

  // current item
  logic [REQ_W-1:0]    req_q;
  logic [SERIAL_W-1:0] ack_q;
  logic                list_end_q, send_ok;

  // scan
  logic [IW-1:0] idx, idx_next;
  logic          found, free_found;
  logic [IW-1:0] match_idx, free_idx;

  // result buffer
  res_t       rbuf [MAX_RESULTS];
  logic [3:0] n;
  logic [2:0] rd;

  // slot memory
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  slot_t         ram_wdata, ram_rdata;

  logic       push;
  res_t       push_res;
  logic       cap_hit, base_ok, slot_v, expire;
  logic [7:0] lim;
  logic       send_ok_in;
  logic [IW-1:0] target;

  always_comb begin
    lim = (8'(window_limit) > 8'(WINDOW_SLOTS)) ? 8'(WINDOW_SLOTS) : 8'(window_limit);
    base_ok = 8'(pend) < lim;
  end

  assign ready_now   = !stopped && !held && base_ok;
  assign send_ok_in  = ready_now && !message_empty;

  // result cap per item kind
  always_comb begin
    case (req_q)
      REQ_TICK: cap_hit = (n >= 4'(MAX_RESULTS));
      REQ_ACK:  cap_hit = (n >= 4'(MAX_RESULTS - 1));
      default:  cap_hit = 1'b0;
    endcase
  end

  assign sts.need_scan   = (req_type == REQ_TICK) || (req_type == REQ_ACK) ||
                           ((req_type == REQ_SEND) && send_ok_in);
  assign sts.scan_done   = (idx == LAST_IDX) || cap_hit;
  assign sts.has_results = (n != 4'd0);
  assign sts.pop_last    = (4'(rd) == n - 4'd1);

  assign res         = rbuf[rd];
  assign last_result = sts.pop_last;

  // read one slot ahead of the scan
  always_comb begin
    if (cmd.load) begin
      idx_next = '0;
    end else if (cmd.step && idx != LAST_IDX) begin
      idx_next = idx + IW'(1);
    end else begin
      idx_next = idx;
    end
  end

  assign slot_v  = valid[idx];
  assign expire  = ram_rdata.countdown <= 8'd1;
  assign target  = found ? match_idx : free_idx;

  // per-slot work and finishing actions
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = ram_rdata;
    push      = 1'b0;
    push_res  = '0;
    if (cmd.step && !cap_hit && slot_v) begin
      case (req_q)
        REQ_ACK: begin
          if (ack_q <= SMAX && ram_rdata.serial == ack_q) begin
            push     = 1'b1;
            push_res = '{EV_DELIVERED, ack_q, 1'b0, SLOT_W'(idx)};
          end
        end
        REQ_TICK: begin
          if (!expire) begin
            ram_we              = 1'b1;
            ram_wdata.countdown = ram_rdata.countdown - 8'd1;
          end else if (held) begin
            ram_we              = 1'b1;
            ram_wdata.countdown = ack_timeout;
          end else if (stopped || ram_rdata.retries >= max_tx) begin
            push     = 1'b1;
            push_res = '{EV_FAILED, ram_rdata.serial, 1'b0, SLOT_W'(idx)};
          end else begin
            ram_we              = 1'b1;
            ram_wdata.countdown = ack_timeout;
            ram_wdata.retries   = (ram_rdata.retries == 4'hF) ? 4'hF
                                                              : ram_rdata.retries + 4'd1;
            push     = 1'b1;
            push_res = '{EV_RETRANSMIT, ram_rdata.serial, 1'b1, SLOT_W'(idx)};
          end
        end
        default: ;
      endcase
    end else if (cmd.finish) begin
      case (req_q)
        REQ_START: begin
          if (!held && base_ok) begin
            push     = 1'b1;
            push_res = '{EV_READY, '0, 1'b0, '0};
          end
        end
        REQ_FLOW_ON: begin
          if (!stopped && base_ok) begin
            push     = 1'b1;
            push_res = '{EV_READY, '0, 1'b0, '0};
          end
        end
        REQ_SEND: begin
          push = 1'b1;
          if (!send_ok) begin
            push_res = '{EV_REJECTED, '0, 1'b0, '0};
          end else begin
            ram_we    = 1'b1;
            ram_waddr = target;
            ram_wdata = '{counter, 4'd1, ack_timeout};
            push_res  = '{EV_TRANSMIT, counter, 1'b0, SLOT_W'(target)};
          end
        end
        REQ_ACK: begin
          if (list_end_q && ready_now) begin
            push     = 1'b1;
            push_res = '{EV_READY, '0, 1'b0, '0};
          end
        end
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      window_limit <= 4'd8;
      max_tx       <= 4'd3;
      ack_timeout  <= 8'd60;
      stopped      <= 1'b1;
      held         <= 1'b0;
      counter      <= '0;
      valid        <= '0;
      pend         <= '0;
      n            <= '0;
      rd           <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WINDOW_LIMIT: window_limit <= cfg_data[3:0];
          CFG_MAX_TX:       max_tx       <= cfg_data[3:0];
          CFG_ACK_TIMEOUT:  ack_timeout  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        n  <= '0;
        rd <= '0;
        if (req_type == REQ_SEND && send_ok_in) begin
          counter <= (counter >= SMAX) ? '0 : counter + SERIAL_W'(1);
        end
      end
      if (push) begin
        n <= n + 4'd1;
      end
      if (cmd.pop) begin
        rd <= rd + 3'd1;
      end
      // free slots that report delivered or failed
      if (cmd.step && push && push_res.kind != EV_RETRANSMIT) begin
        valid[idx] <= 1'b0;
        pend       <= pend - PW'(1);
      end
      if (cmd.finish) begin
        case (req_q)
          REQ_START:    stopped <= 1'b0;
          REQ_STOP:     stopped <= 1'b1;
          REQ_FLOW_OFF: held    <= 1'b1;
          REQ_FLOW_ON:  held    <= 1'b0;
          REQ_SEND: begin
            if (send_ok) begin
              valid[target] <= 1'b1;
              if (!found) pend <= pend + PW'(1);
            end
          end
          default: ;
        endcase
      end
    end
  end

  // item fields, scan trackers and result buffer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q      <= req_type;
      ack_q      <= ack_serial;
      list_end_q <= ack_list_end;
      send_ok    <= send_ok_in;
      found      <= 1'b0;
      free_found <= 1'b0;
      match_idx  <= '0;
      free_idx   <= '0;
    end
    if (cmd.step && req_q == REQ_SEND) begin
      if (slot_v && !found && ram_rdata.serial == counter) begin
        found     <= 1'b1;
        match_idx <= idx;
      end
      if (!slot_v && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= idx;
      end
    end
    if (push) begin
      rbuf[n[2:0]] <= push_res;
    end
    idx <= idx_next;
  end

  awre_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (WINDOW_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_next),
    .rdata (ram_rdata)
  );

  // pending count tracks the valid bits
  a_pend_count: assert property (@(posedge clk) disable iff (rst)
    32'(pend) == $countones(valid))
    else $error("pending count out of step with valid slots");

  // buffer never overfills
  a_buf_bound: assert property (@(posedge clk) disable iff (rst)
    n <= 4'(MAX_RESULTS))
    else $error("result buffer overflow");

  // a beat is only taken from a filled entry
  a_pop_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> (4'(rd) < n))
    else $error("result taken beyond buffer fill");
endmodule

@@ rtl/ack_window_retransmit_engine_top.sv @@
// Sender side of an acknowledged message link with a window of WINDOW_SLOTS
// pending messages. One item is handled at a time.
// Start, stop, flow, unknown and rejected send requests do not touch the
// slot memory. They go from load straight to the finish step and then hand
// out any results.
// Accepted sends, acks and ticks walk the slot memory through its single
// read port, one slot per cycle, then take the finish step and hand out
// their result beats. A tick scan ends early once its result buffer is full,
// an ack scan once only one entry is left for its ready event.
// An item makes at most eight beats, and each beat waits for the result
// side to take it.
// No clearing pass is needed after reset.
module ack_window_retransmit_engine_top import awre_pkg::*; #(
  parameter int WINDOW_SLOTS = DEF_WINDOW_SLOTS,
  parameter int SERIAL_MAX   = DEF_SERIAL_MAX
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  awre_req_if.sink          req,
  awre_evt_if.source        evt
);
  cmd_t cmd;
  sts_t sts;
  res_t res;

  awre_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (evt.valid),
    .out_ready (evt.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  awre_dp #(
    .WINDOW_SLOTS (WINDOW_SLOTS),
    .SERIAL_MAX   (SERIAL_MAX)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_type      (req.req_type),
    .message_empty (req.message_empty),
    .ack_serial    (req.ack_serial),
    .ack_list_end  (req.ack_list_end),
    .cmd           (cmd),
    .sts           (sts),
    .res           (res),
    .ready_now     (evt.ready_now),
    .last_result   (evt.last_result)
  );

  // drive the result beat
  assign evt.event_kind     = res.kind;
  assign evt.serial_number  = res.serial;
  assign evt.duplicate_mark = res.dup;
  assign evt.slot_index     = res.slot;
endmodule

@@ sim/tb_ack_window_retransmit_engine_top.sv @@
`timescale 1ns / 1ps

module tb_ack_window_retransmit_engine_top;
  import awre_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 3'd7;
  localparam int SLOTS     = DEF_WINDOW_SLOTS;
  localparam int SER_TOP   = DEF_SERIAL_MAX;
  localparam int SETTLE    = 40;
  localparam int STALL_LEN = 400;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SERIAL_W-1:0] serial;
    logic                dup;
    logic [SLOT_W-1:0]   slot;
    logic                rdy;
    logic                last;
  } evt_beat_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CIDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  awre_req_if req_if ();
  awre_evt_if evt_if ();

  ack_window_retransmit_engine_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_if.sink),
    .evt       (evt_if.source)
  );

  // shadow copy of the engine
  int wnd_limit, tx_limit, timeout_ld;
  bit link_down, flow_off;
  int serial_ctr;
  bit slot_busy [SLOTS];
  int slot_ser  [SLOTS];
  int slot_sent [SLOTS];
  int slot_cnt  [SLOTS];

  evt_beat_t pending_events[$];
  int  mismatches = 0;
  bit  no_idle;
  bit  stall_request = 1'b0;
  bit  stall_taken   = 1'b0;
  int  stall_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  function automatic bit link_open();
    int lim, busy;
    lim  = (wnd_limit > SLOTS) ? SLOTS : wnd_limit;
    busy = 0;
    for (int i = 0; i < SLOTS; i++) busy += int'(slot_busy[i]);
    return !link_down && !flow_off && busy < lim;
  endfunction

  // work out the events one accepted request causes
  function automatic void predict_events(logic [REQ_W-1:0] rq, bit empty,
                                         int ack, bit list_end);
    evt_beat_t ev[$];
    evt_beat_t b;
    int pick;
    bit r;
    b = '{default: '0};
    case (rq)
      REQ_START, REQ_FLOW_ON: begin
        if (rq == REQ_START) link_down = 0; else flow_off = 0;
        if (link_open()) begin b.kind = EV_READY; ev.push_back(b); end
      end
      REQ_STOP:     link_down = 1;
      REQ_FLOW_OFF: flow_off = 1;
      REQ_SEND: begin
        if (!link_open() || empty) begin
          b.kind = EV_REJECTED; ev.push_back(b);
        end else begin
          serial_ctr++;
          if (serial_ctr > SER_TOP) serial_ctr = 0;
          pick = -1;
          for (int i = 0; i < SLOTS; i++)
            if (pick < 0 && slot_busy[i] && slot_ser[i] == serial_ctr) pick = i;
          for (int i = 0; i < SLOTS; i++)
            if (pick < 0 && !slot_busy[i]) pick = i;
          if (pick < 0) begin
            b.kind = EV_REJECTED; ev.push_back(b);
          end else begin
            slot_busy[pick] = 1;
            slot_ser[pick]  = serial_ctr;
            slot_sent[pick] = 1;
            slot_cnt[pick]  = timeout_ld;
            b.kind   = EV_TRANSMIT;
            b.serial = SERIAL_W'(serial_ctr);
            b.slot   = SLOT_W'(pick);
            ev.push_back(b);
          end
        end
      end
      REQ_ACK: begin
        for (int i = 0; i < SLOTS && ev.size() < MAX_RESULTS - 1; i++)
          if (slot_busy[i] && ack <= SER_TOP && slot_ser[i] == ack) begin
            slot_busy[i] = 0;
            b.kind   = EV_DELIVERED;
            b.serial = SERIAL_W'(ack);
            b.slot   = SLOT_W'(i);
            ev.push_back(b);
          end
        if (list_end && link_open()) begin
          b = '{default: '0}; b.kind = EV_READY; ev.push_back(b);
        end
      end
      REQ_TICK: begin
        for (int i = 0; i < SLOTS && ev.size() < MAX_RESULTS; i++) begin
          if (!slot_busy[i]) continue;
          if (slot_cnt[i] > 1) begin slot_cnt[i]--; continue; end
          b.serial = SERIAL_W'(slot_ser[i]);
          b.slot   = SLOT_W'(i);
          if (flow_off) begin
            slot_cnt[i] = timeout_ld;
          end else if (link_down || slot_sent[i] >= tx_limit) begin
            slot_busy[i] = 0;
            b.kind = EV_FAILED; b.dup = 0; ev.push_back(b);
          end else begin
            if (slot_sent[i] < 15) slot_sent[i]++;
            slot_cnt[i] = timeout_ld;
            b.kind = EV_RETRANSMIT; b.dup = 1; ev.push_back(b);
          end
        end
      end
      default: ;
    endcase
    r = link_open();
    foreach (ev[k]) begin
      ev[k].rdy  = r;
      ev[k].last = (k == ev.size() - 1);
      pending_events.push_back(ev[k]);
    end
  endfunction

  // offer one request beat and wait until it is taken
  task automatic send_req(logic [REQ_W-1:0] rq, bit empty = 0, int ack = 0,
                          bit list_end = 0);
    if (!no_idle && $urandom_range(99) < 33) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    req_if.valid         <= 1'b1;
    req_if.req_type      <= rq;
    req_if.message_empty <= empty;
    req_if.ack_serial    <= ack[SERIAL_W-1:0];
    req_if.ack_list_end  <= list_end;
    do @(posedge clk); while (!req_if.ready);
    predict_events(rq, empty, ack, list_end);
  endtask

  // hold the input and wait until every event has come out
  task automatic drain();
    req_if.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, int val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_WINDOW_LIMIT: wnd_limit  = val & 15;
      CFG_MAX_TX:       tx_limit   = val & 15;
      CFG_ACK_TIMEOUT:  timeout_ld = val & 255;
      default: ;
    endcase
  endtask

  task automatic set_regs(int wl, int mt, int to);
    write_reg(CFG_WINDOW_LIMIT, wl);
    write_reg(CFG_MAX_TX, mt);
    write_reg(CFG_ACK_TIMEOUT, to);
  endtask

  // event sink: random back-pressure, with one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      evt_if.ready <= 1'b0;
    end else if (stall_request && !stall_taken) begin
      stall_taken  = 1'b1;
      stall_cycles = STALL_LEN;
      evt_if.ready <= 1'b0;
    end else if (stall_cycles > 0) begin
      stall_cycles--;
      evt_if.ready <= 1'b0;
    end else begin
      evt_if.ready <= no_idle || ($urandom_range(99) >= 33);
    end
  end

  // compare each event beat with the oldest prediction
  always @(posedge clk) begin
    evt_beat_t exp_b, got;
    if (!rst && evt_if.valid && evt_if.ready) begin
      got.kind   = evt_if.event_kind;
      got.serial = evt_if.serial_number;
      got.dup    = evt_if.duplicate_mark;
      got.slot   = evt_if.slot_index;
      got.rdy    = evt_if.ready_now;
      got.last   = evt_if.last_result;
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected event: kind %0d serial %0d", got.kind, got.serial);
      end else begin
        exp_b = pending_events.pop_front();
        if (got !== exp_b) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp k%0d s%0d d%0d i%0d r%0d l%0d, ",
                      "got k%0d s%0d d%0d i%0d r%0d l%0d"},
                     exp_b.kind, exp_b.serial, exp_b.dup, exp_b.slot, exp_b.rdy,
                     exp_b.last, got.kind, got.serial, got.dup, got.slot, got.rdy,
                     got.last);
        end
      end
    end
  end

  task automatic test_basic_requests();
    send_req(REQ_SEND, 0);
    send_req(REQ_START);
    send_req(REQ_SEND, 1);
    send_req(REQ_SEND, 0);
    send_req(REQ_SEND, 0);
    send_req(REQ_ACK, 0, 1, 0);
    send_req(REQ_ACK, 0, 2, 1);
    send_req(REQ_ACK, 0, 1023, 1);
    send_req(REQ_ACK, 0, 0, 1);
    send_req(REQ_FLOW_OFF);
    send_req(REQ_SEND, 0);
    send_req(REQ_FLOW_ON);
    send_req(REQ_UNKNOWN, 1, 1023, 1);
    send_req(REQ_TICK);
    send_req(REQ_STOP);
    send_req(REQ_SEND, 0);
    send_req(REQ_START);
  endtask

  task automatic test_expiry();
    // zero timeout and zero transmissions: all eight fail in one tick
    set_regs(15, 0, 0);
    for (int i = 0; i < SLOTS; i++) send_req(REQ_SEND, 0);
    send_req(REQ_SEND, 0);
    send_req(REQ_TICK);
    // retries run up to the limit of 15 and fail; later ticks find no pending slot
    set_regs(8, 15, 1);
    send_req(REQ_SEND, 0);
    send_req(REQ_SEND, 0);
    repeat (16) send_req(REQ_TICK);
    send_req(REQ_FLOW_OFF);
    send_req(REQ_TICK);
    send_req(REQ_FLOW_ON);
    send_req(REQ_STOP);
    send_req(REQ_TICK);
    send_req(REQ_START);
  endtask

  task automatic test_window_limit();
    set_regs(0, 3, 255);
    send_req(REQ_START);
    send_req(REQ_SEND, 0);
    set_regs(1, 1, 2);
    send_req(REQ_SEND, 0);
    send_req(REQ_SEND, 0);
    send_req(REQ_TICK);
    send_req(REQ_TICK);
    send_req(REQ_START);
  endtask

  task automatic random_burst(int count);
    int sel, ack;
    for (int n = 0; n < count; n++) begin
      sel = int'($urandom_range(99));
      if (sel < 35) begin
        send_req(REQ_SEND, $urandom_range(99) < 8);
      end else if (sel < 60) begin
        if ($urandom_range(9) < 2) ack = int'($urandom_range(1023));
        else ack = (serial_ctr + SER_TOP + 1 - int'($urandom_range(9))) % (SER_TOP + 1);
        send_req(REQ_ACK, 0, ack, 1'($urandom_range(1)));
      end else if (sel < 82) begin
        send_req(REQ_TICK);
      end else if (sel < 98) begin
        send_req(REQ_W'($urandom_range(3)));
      end else begin
        send_req(REQ_UNKNOWN, 1'($urandom_range(1)), int'($urandom_range(1023)),
                 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic test_random();
    set_regs(8, 3, 2);
    send_req(REQ_START);
    random_burst(45);
    set_regs(3, 2, 1);
    send_req(REQ_START); send_req(REQ_FLOW_ON);
    random_burst(45);
    no_idle = 1;
    set_regs(15, 15, 3);
    send_req(REQ_START); send_req(REQ_FLOW_ON);
    random_burst(45);
    no_idle = 0;
    set_regs(1, 1, 255);
    send_req(REQ_START); send_req(REQ_FLOW_ON);
    random_burst(35);
    set_regs($urandom_range(15), $urandom_range(15), $urandom_range(4));
    send_req(REQ_START); send_req(REQ_FLOW_ON);
    random_burst(45);
  endtask

  // sink holds off while requests keep coming, then sender pauses
  task automatic test_backpressure();
    set_regs(8, 15, 1);
    send_req(REQ_START);
    send_req(REQ_FLOW_ON);
    stall_request = 1'b1;
    repeat (8) send_req(REQ_SEND, 0);
    repeat (10) send_req(REQ_TICK);
    drain();
    random_burst(30);
  endtask

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    req_if.valid = 1'b0;
    req_if.req_type      = '0;
    req_if.message_empty = 1'b0;
    req_if.ack_serial    = '0;
    req_if.ack_list_end  = 1'b0;
    no_idle      = 0;
    wnd_limit = 8; tx_limit = 3; timeout_ld = 60;
    link_down = 1; flow_off = 0; serial_ctr = 0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_busy[i] = 0; slot_ser[i] = 0; slot_sent[i] = 0; slot_cnt[i] = 0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_requests();
    test_expiry();
    test_window_limit();
    test_random();
    test_backpressure();
    drain();

    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
